// ----- design/v2alu_pkg.sv -----
package v2alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int W = 32;
    localparam int SQ_W = 64;
    localparam int SQRT_W = 32;
    localparam int DIV_W = 32 + 24 + 1;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_NEG   = 4'd2,
        MODE_SCALE = 4'd3,
        MODE_DIV   = 4'd4,
        MODE_DOT   = 4'd5,
        MODE_SQMAG = 4'd6,
        MODE_MAG   = 4'd7,
        MODE_NORM  = 4'd8
    } mode_t;

    localparam logic signed [W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] SAT_MIN = 32'sh8000_0000;

    // clamp a 66-bit signed value to 32 bits
    function automatic logic [W:0] sat66(input logic signed [65:0] v);
        logic [W:0] r;
        if (v > 66'sd2147483647)
        begin
            r = {1'b1, SAT_MAX};
        end
        else if (v < -66'sd2147483648)
        begin
            r = {1'b1, SAT_MIN};
        end
        else
        begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- design/v2alu_divpipe.sv -----
module v2alu_divpipe
    import v2alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TAG_W = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [TAG_W-1:0]   tag_in,
    input  logic [W:0]         num_mag,
    input  logic [W:0]         den_mag,
    output logic [TAG_W-1:0]   tag_out,
    output logic [DIV_W-1:0]   quot
);
    // restoring divider, one quotient bit per stage, on num<<F
    localparam int NW = W + 1 + FRAC_BITS + 1;
    localparam int ST = NW;

    logic [NW-1:0]    n_reg    [0:ST];
    logic [W+1:0]     r_reg    [0:ST];
    logic [W:0]       d_reg    [0:ST];
    logic [TAG_W-1:0] t_reg    [0:ST];
    logic [NW-1:0]    q_reg    [0:ST];

    // rounding: add den/2 via remainder comparison at the end
    logic [NW-1:0] n_start;
    assign n_start = NW'(num_mag) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0] <= n_start;
            r_reg[0] <= '0;
            d_reg[0] <= den_mag;
            t_reg[0] <= tag_in;
            q_reg[0] <= '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < ST; g++)
        begin : g_st
            logic [W+1:0] sh;
            logic [W+2:0] df;
            assign sh = {r_reg[g][W:0], n_reg[g][NW-1]};
            assign df = {1'b0, sh} - {2'b00, d_reg[g]};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    n_reg[g+1] <= n_reg[g] << 1;
                    r_reg[g+1] <= df[W+2] ? sh : df[W+1:0];
                    q_reg[g+1] <= {q_reg[g][NW-2:0], ~df[W+2]};
                    d_reg[g+1] <= d_reg[g];
                    t_reg[g+1] <= t_reg[g];
                end
            end
        end
    endgenerate

    // round to nearest, ties up: remainder*2 >= den
    logic [W+2:0] r2;
    assign r2 = {r_reg[ST], 1'b0};
    assign quot = DIV_W'(q_reg[ST]) + DIV_W'(r2 >= {2'b00, d_reg[ST]});
    assign tag_out = t_reg[ST];

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

// ----- design/vec2_lane_alu.sv -----
// channel | valid  | stall  | payload
// in      | valid  | stall  | mode a_x a_y b_x b_y factor
// out     | ovalid | ostall | r_x r_y r_scalar overflow div_zero
// one item per cycle when the output is not stalled
// pipeline: three input, product and sum stages, 16 root stages, one divider
// set-up stage, one divider stage per quotient bit plus its input register,
// then the output register
// reset clears the valid bits only; a stall freezes every stage
module vec2_lane_alu
    import v2alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [3:0]          mode,
    input  logic signed [W-1:0] a_x,
    input  logic signed [W-1:0] a_y,
    input  logic signed [W-1:0] b_x,
    input  logic signed [W-1:0] b_y,
    input  logic signed [W-1:0] factor,
    output logic                ovalid,
    input  logic                ostall,
    output logic signed [W-1:0] r_x,
    output logic signed [W-1:0] r_y,
    output logic signed [W-1:0] r_scalar,
    output logic                overflow,
    output logic                div_zero
);
    localparam int SQ_ST = 16;
    localparam int NW = W + 1 + FRAC_BITS + 1;
    localparam int DEPTH = 3 + SQ_ST + 1 + (NW + 1) + 1;

    // whole pipe advances together; output register frees when taken
    logic adv;
    logic [DEPTH-1:0] v_reg;
    assign adv = !ostall || !v_reg[DEPTH-1];
    assign stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], valid};
        end
    end

    // stage 1: register inputs
    logic [3:0] m1_reg;
    logic signed [W-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, f1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg <= mode; ax1_reg <= a_x; ay1_reg <= a_y;
            bx1_reg <= b_x; by1_reg <= b_y; f1_reg <= factor;
        end
    end

    // stage 2: products and add/sub/neg
    logic signed [W-1:0] mx, my;
    always_comb
    begin
        unique case (m1_reg)
            MODE_SCALE: begin mx = f1_reg;  my = f1_reg;  end
            MODE_DOT:   begin mx = bx1_reg; my = by1_reg; end
            default:    begin mx = ax1_reg; my = ay1_reg; end
        endcase
    end
    logic [3:0] m2_reg;
    logic signed [2*W-1:0] px2_reg, py2_reg;
    logic signed [W:0] sx2_reg, sy2_reg;
    logic signed [W-1:0] ax2_reg, ay2_reg, f2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_reg <= m1_reg;
            px2_reg <= ax1_reg * mx;
            py2_reg <= ay1_reg * my;
            ax2_reg <= ax1_reg; ay2_reg <= ay1_reg; f2_reg <= f1_reg;
            unique case (m1_reg)
                MODE_ADD: begin
                    sx2_reg <= (W+1)'(ax1_reg) + (W+1)'(bx1_reg);
                    sy2_reg <= (W+1)'(ay1_reg) + (W+1)'(by1_reg);
                end
                MODE_SUB: begin
                    sx2_reg <= (W+1)'(ax1_reg) - (W+1)'(bx1_reg);
                    sy2_reg <= (W+1)'(ay1_reg) - (W+1)'(by1_reg);
                end
                default: begin
                    sx2_reg <= -(W+1)'(ax1_reg);
                    sy2_reg <= -(W+1)'(ay1_reg);
                end
            endcase
        end
    end

    // stage 3: sums and rounding shift
    logic signed [2*W+1:0] psum, rnd;
    assign psum = (m2_reg == MODE_SCALE) ? (2*W+2)'(px2_reg)
                                         : (2*W+2)'(px2_reg) + (2*W+2)'(py2_reg);
    assign rnd = (psum + ((2*W+2)'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;

    logic [3:0] m3_reg;
    logic [W:0] rx3_reg, ry3_reg, rs3_reg;
    logic [SQ_W-1:0] n3_reg;
    logic signed [W-1:0] ax3_reg, ay3_reg, f3_reg;
    logic [W:0] satx, saty, sats, scx, scy;
    assign satx = sat66(66'(sx2_reg));
    assign saty = sat66(66'(sy2_reg));
    assign sats = sat66(66'(rnd));
    assign scx = sat66(66'((((2*W+2)'(px2_reg)) + ((2*W+2)'(1) <<< (FRAC_BITS-1)))
                 >>> FRAC_BITS));
    assign scy = sat66(66'((((2*W+2)'(py2_reg)) + ((2*W+2)'(1) <<< (FRAC_BITS-1)))
                 >>> FRAC_BITS));
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg <= m2_reg;
            ax3_reg <= ax2_reg; ay3_reg <= ay2_reg; f3_reg <= f2_reg;
            n3_reg <= SQ_W'(psum);
            rs3_reg <= sats;
            if (m2_reg == MODE_SCALE)
            begin
                rx3_reg <= scx; ry3_reg <= scy;
            end
            else
            begin
                rx3_reg <= satx; ry3_reg <= saty;
            end
        end
    end

    // square root: two result bits per stage, 16 stages over 64-bit radicand
    logic [SQ_W:0]   sn_reg [0:SQ_ST];
    logic [SQ_W:0]   sr_reg [0:SQ_ST];
    logic [SQRT_W:0] sq_reg [0:SQ_ST];
    always_comb
    begin
        sn_reg[0] = {1'b0, n3_reg};
        sr_reg[0] = '0;
        sq_reg[0] = '0;
    end
    genvar g;
    generate
        for (g = 0; g < SQ_ST; g++)
        begin : g_sq
            logic [SQ_W:0] r0, r1, t0, t1;
            logic [SQRT_W:0] q0, q1;
            logic [SQ_W+1:0] d0, d1;
            logic [SQ_W:0] r_n;
            logic [SQRT_W:0] q_n;
            always_comb
            begin
                r0 = {sr_reg[g][SQ_W-2:0], sn_reg[g][SQ_W-1-4*g -: 2]};
                t0 = {sq_reg[g][SQRT_W-2:0], 2'b01} & {(SQ_W+1){1'b1}};
                d0 = {1'b0, r0} - {1'b0, t0};
                q0 = {sq_reg[g][SQRT_W-1:0], ~d0[SQ_W+1]};
                r1 = d0[SQ_W+1] ? r0 : d0[SQ_W:0];
                r1 = {r1[SQ_W-2:0], sn_reg[g][SQ_W-3-4*g -: 2]};
                t1 = {q0[SQRT_W-2:0], 2'b01} & {(SQ_W+1){1'b1}};
                d1 = {1'b0, r1} - {1'b0, t1};
                q1 = {q0[SQRT_W-1:0], ~d1[SQ_W+1]};
                r_n = d1[SQ_W+1] ? r1 : d1[SQ_W:0];
                q_n = q1;
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sn_reg[g+1] <= sn_reg[g];
                    sr_reg[g+1] <= r_n;
                    sq_reg[g+1] <= q_n;
                end
            end
        end
    endgenerate

    // carry the rest of stage 3 alongside the root
    typedef struct packed {
        logic [3:0] m;
        logic [W:0] rx, ry, rs;
        logic signed [W-1:0] ax, ay, f;
    } side_t;
    side_t sd_reg [0:SQ_ST];
    always_comb
    begin
        sd_reg[0] = '{m: m3_reg, rx: rx3_reg, ry: ry3_reg, rs: rs3_reg,
                      ax: ax3_reg, ay: ay3_reg, f: f3_reg};
    end
    generate
        for (g = 0; g < SQ_ST; g++)
        begin : g_sd
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sd_reg[g+1] <= sd_reg[g];
                end
            end
        end
    endgenerate

    // round root: +1 when remainder exceeds root
    logic [SQRT_W:0] mag;
    assign mag = sq_reg[SQ_ST] + (SQRT_W+1)'(sr_reg[SQ_ST] > (SQ_W+1)'(sq_reg[SQ_ST]));

    // stage: set up divider operands
    typedef struct packed {
        logic [3:0] m;
        logic [W:0] rx, ry, rs;
        logic dneg, xneg, yneg, dz, mag_ov;
    } tag_t;
    localparam int TAG_W = $bits(tag_t);

    tag_t tg_reg;
    logic [W:0] nx_reg, ny_reg, dm_reg;
    logic [W:0] fmag, dsel;
    logic [W-1:0] magc;
    side_t s;
    assign s = sd_reg[SQ_ST];
    assign fmag = s.f[W-1] ? -(W+1)'(s.f) : (W+1)'(s.f);
    assign dsel = (s.m == MODE_NORM) ? mag : fmag;
    assign magc = mag[W:W-1] != 2'b00 ? SAT_MAX : mag[W-1:0];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tg_reg.m <= s.m;
            tg_reg.rx <= s.rx;
            tg_reg.ry <= s.ry;
            tg_reg.rs <= (s.m == MODE_MAG) ? {1'b0, magc} : s.rs;
            tg_reg.mag_ov <= mag[W:W-1] != 2'b00;
            tg_reg.dneg <= (s.m == MODE_DIV) && s.f[W-1];
            tg_reg.xneg <= s.ax[W-1];
            tg_reg.yneg <= s.ay[W-1];
            tg_reg.dz <= (dsel == '0);
            nx_reg <= s.ax[W-1] ? -(W+1)'(s.ax) : (W+1)'(s.ax);
            ny_reg <= s.ay[W-1] ? -(W+1)'(s.ay) : (W+1)'(s.ay);
            dm_reg <= (dsel == '0) ? (W+1)'(1) : dsel;
        end
    end

    logic [TAG_W-1:0] tx_out, ty_out;
    logic [DIV_W-1:0] qx, qy;
    v2alu_divpipe #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_divx (
        .clk(clk), .rst_n(rst_n), .adv(adv), .tag_in(tg_reg),
        .num_mag(nx_reg), .den_mag(dm_reg), .tag_out(tx_out), .quot(qx));
    v2alu_divpipe #(.FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_divy (
        .clk(clk), .rst_n(rst_n), .adv(adv), .tag_in(1'b0),
        .num_mag(ny_reg), .den_mag(dm_reg), .tag_out(ty_out[0]), .quot(qy));
    assign ty_out[TAG_W-1:1] = '0;

    // final stage: sign, saturation and mode select
    tag_t t;
    assign t = tx_out;
    logic signed [65:0] dx, dy;
    logic [W:0] dsx, dsy;
    assign dx = (t.xneg != t.dneg) ? -66'(qx) : 66'(qx);
    assign dy = (t.yneg != t.dneg) ? -66'(qy) : 66'(qy);
    assign dsx = sat66(dx);
    assign dsy = sat66(dy);

    logic signed [W-1:0] rx_reg, ry_reg, rs_reg;
    logic ov_reg, dz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg <= '0; ry_reg <= '0; rs_reg <= '0; ov_reg <= 1'b0; dz_reg <= 1'b0;
            unique case (t.m)
                MODE_ADD, MODE_SUB, MODE_NEG, MODE_SCALE:
                begin
                    rx_reg <= t.rx[W-1:0]; ry_reg <= t.ry[W-1:0];
                    ov_reg <= t.rx[W] | t.ry[W];
                end
                MODE_DOT, MODE_SQMAG:
                begin
                    rs_reg <= t.rs[W-1:0]; ov_reg <= t.rs[W];
                end
                MODE_MAG:
                begin
                    rs_reg <= t.rs[W-1:0]; ov_reg <= t.mag_ov;
                end
                MODE_DIV, MODE_NORM:
                begin
                    if (t.dz)
                    begin
                        dz_reg <= 1'b1;
                    end
                    else
                    begin
                        rx_reg <= dsx[W-1:0]; ry_reg <= dsy[W-1:0];
                        ov_reg <= dsx[W] | dsy[W];
                    end
                end
                default: ;
            endcase
        end
    end

    assign ovalid = v_reg[DEPTH-1];
    assign r_x = rx_reg;
    assign r_y = ry_reg;
    assign r_scalar = rs_reg;
    assign overflow = ov_reg;
    assign div_zero = dz_reg;

    logic [TAG_W-1:0] unused_ty;
    assign unused_ty = ty_out;
endmodule

// ----- design/v2alu_checker.sv -----
module v2alu_checker
    import v2alu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic stall,
    input logic ovalid,
    input logic ostall,
    input logic signed [W-1:0] r_x,
    input logic signed [W-1:0] r_y,
    input logic signed [W-1:0] r_scalar,
    input logic overflow,
    input logic div_zero
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid && ostall |=> ovalid && $stable(r_x) && $stable(r_scalar))
        else $error("held word changed");
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> ovalid && ostall)
        else $error("stall without full output");
    a_dz_vec: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid && div_zero |-> r_x == '0 && r_y == '0 && r_scalar == '0 && !overflow)
        else $error("div_zero with nonzero result");
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid && r_scalar != '0 |-> r_x == '0 && r_y == '0)
        else $error("scalar and vector result together");
    a_rst: assert property (@(posedge clk) !rst_n |=> !ovalid)
        else $error("valid after reset");
endmodule

bind vec2_lane_alu v2alu_checker u_chk (.*);
